### src/rx_byte_ring_buffer_drop_oldest_defines.svh
// Assertion helpers for the checker of the receive ring buffer.
`ifndef RX_BYTE_RING_BUFFER_DROP_OLDEST_DEFINES_SVH
`define RX_BYTE_RING_BUFFER_DROP_OLDEST_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RXRB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("ring buffer check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define RXRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("ring buffer check failed");

`endif

### src/rxrb_pkg.sv
package rxrb_pkg;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } rxrb_op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } rxrb_state_e;

  localparam logic [7:0] EMPTY_MARK = 8'hFF;

  typedef struct packed {
    logic [7:0] read_data;
    logic       pop_was_empty;
    logic       buffer_empty;
  } rxrb_result_t;

endpackage

### src/rxrb_mem.sv
module rxrb_mem #(
  parameter int BufferDepth = 64,
  parameter int AddrWidth   = 6
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [AddrWidth-1:0] wr_addr_i,
  input  logic [7:0]           wr_data_i,
  input  logic                 rd_en_i,
  input  logic [AddrWidth-1:0] rd_addr_i,
  output logic [7:0]           rd_data_o
);

  logic [7:0] mem_q [BufferDepth];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### src/rxrb_ctrl.sv
module rxrb_ctrl #(
  parameter int BufferDepth = 64,
  parameter int AddrWidth   = 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  rxrb_pkg::rxrb_op_e     operation_i,
  input  logic                   out_free_i,
  output logic                   res_valid_o,
  output logic                   res_use_mem_o,
  output rxrb_pkg::rxrb_result_t res_o,
  output logic                   wr_en_o,
  output logic [AddrWidth-1:0]   wr_addr_o,
  output logic                   rd_en_o,
  output logic [AddrWidth-1:0]   rd_addr_o
);
  import rxrb_pkg::*;

  localparam logic [AddrWidth-1:0] LastIdx = AddrWidth'(BufferDepth - 1);

  rxrb_state_e          state_q, state_d;
  logic [AddrWidth-1:0] wp_q, wp_d, rp_q, rp_d;
  logic                 empty_q, empty_d;
  logic [AddrWidth-1:0] wp_inc, wp_inc2, rp_inc;

  function automatic logic [AddrWidth-1:0] wrap_inc(input logic [AddrWidth-1:0] p);
    wrap_inc = (p == LastIdx) ? '0 : p + 1'b1;
  endfunction

  assign wp_inc  = wrap_inc(wp_q);
  assign wp_inc2 = wrap_inc(wp_inc);
  assign rp_inc  = wrap_inc(rp_q);

  assign wr_addr_o = wp_q;
  assign rd_addr_o = rp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wp_q    <= '0;
      rp_q    <= '0;
      empty_q <= 1'b1;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      empty_q <= empty_d;
    end
  end

  always_comb begin
    state_d             = state_q;
    wp_d                = wp_q;
    rp_d                = rp_q;
    empty_d             = empty_q;
    in_ready_o          = 1'b0;
    res_valid_o         = 1'b0;
    res_use_mem_o       = 1'b0;
    res_o.read_data     = '0;
    res_o.pop_was_empty = 1'b0;
    res_o.buffer_empty  = empty_q;
    wr_en_o             = 1'b0;
    rd_en_o             = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = out_free_i;
        if (in_valid_i && out_free_i) begin
          unique case (operation_i)
            OP_PUSH: begin
              wr_en_o            = 1'b1;
              wp_d               = wp_inc;
              empty_d            = 1'b0;
              res_valid_o        = 1'b1;
              res_o.buffer_empty = 1'b0;
              // Keep two slots free: the oldest byte is dropped when the ring fills.
              if (wp_inc2 == rp_q) begin
                rp_d = rp_inc;
              end
            end
            OP_POP: begin
              if (rp_q == wp_q) begin
                empty_d             = 1'b1;
                res_valid_o         = 1'b1;
                res_o.read_data     = EMPTY_MARK;
                res_o.pop_was_empty = 1'b1;
                res_o.buffer_empty  = 1'b1;
              end else begin
                // The byte arrives from the memory's registered read output in the next cycle.
                rd_en_o = 1'b1;
                state_d = ST_READ;
                if (rp_inc == wp_q) begin
                  rp_d    = '0;
                  wp_d    = '0;
                  empty_d = 1'b1;
                end else begin
                  rp_d = rp_inc;
                end
              end
            end
            OP_CLEAR: begin
              wp_d               = '0;
              rp_d               = '0;
              empty_d            = 1'b1;
              res_valid_o        = 1'b1;
              res_o.buffer_empty = 1'b1;
            end
            OP_NOP: begin
              res_valid_o = 1'b1;
            end
            default: begin
              res_valid_o = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        res_valid_o   = 1'b1;
        res_use_mem_o = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### src/rx_byte_ring_buffer_drop_oldest.sv
// Receive byte ring buffer that drops the oldest byte when it fills.
// Input channel (in_valid_i / in_ready_o) carries one request: operation_i
// selects push (store data_byte_i), pop, clear or no operation.
// Output channel (out_valid_o / out_ready_i) returns exactly one result per
// request: the popped byte (0xFF with pop_was_empty_o set when nothing was
// stored) and the empty flag after the request.
// Push, clear, no-operation and a pop of an empty buffer register their result
// at the accepting edge. A pop that finds data first reads the byte from a
// synchronous memory with a registered read output, then registers the result;
// the next request is taken once that result is registered.
// The ring holds BUFFER_DEPTH - 2 bytes; a push that would fill it further
// discards the oldest byte.
// Reset empties the buffer (pointers to zero, empty flag set); the stored
// bytes are not cleared and need no clearing pass.
// When the receiver stalls, the result waits in the output register and a new
// request is taken only in the cycle the held result leaves.
module rx_byte_ring_buffer_drop_oldest #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o,
  output logic       pop_was_empty_o,
  output logic       buffer_empty_o
);
  import rxrb_pkg::*;

  localparam int AddrWidth = $clog2(BUFFER_DEPTH);

  logic                 out_valid_q;
  rxrb_result_t         out_q;
  logic                 out_free;
  logic                 res_valid, res_use_mem;
  rxrb_result_t         res;
  logic                 wr_en, rd_en;
  logic [AddrWidth-1:0] wr_addr, rd_addr;
  logic [7:0]           rd_data;

  assign out_free = !out_valid_q || out_ready_i;

  rxrb_ctrl #(
    .BufferDepth(BUFFER_DEPTH),
    .AddrWidth  (AddrWidth)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (rxrb_op_e'(operation_i)),
    .out_free_i   (out_free),
    .res_valid_o  (res_valid),
    .res_use_mem_o(res_use_mem),
    .res_o        (res),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr)
  );

  rxrb_mem #(
    .BufferDepth(BUFFER_DEPTH),
    .AddrWidth  (AddrWidth)
  ) u_mem (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(data_byte_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q.read_data     <= res_use_mem ? rd_data : res.read_data;
      out_q.pop_was_empty <= res.pop_was_empty;
      out_q.buffer_empty  <= res.buffer_empty;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = out_q.read_data;
  assign pop_was_empty_o = out_q.pop_was_empty;
  assign buffer_empty_o  = out_q.buffer_empty;

endmodule

### src/rxrb_checker.sv
`include "rx_byte_ring_buffer_drop_oldest_defines.svh"

module rxrb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [1:0] operation_i,
  input logic [7:0] data_byte_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] read_data_o,
  input logic       pop_was_empty_o,
  input logic       buffer_empty_o
);
  import rxrb_pkg::*;

  logic in_fire;
  logic byte_seen;

  assign in_fire   = in_valid_i && in_ready_o;
  // The stored byte itself is free; reading it keeps the port in the checker's view.
  assign byte_seen = ^data_byte_i || !(^data_byte_i);

  // An empty pop always reports the marker byte and an empty buffer.
  `RXRB_ASSERT_NOW(a_empty_pop_marker, clk_i, rst_ni,
                   out_valid_o && pop_was_empty_o,
                   read_data_o == EMPTY_MARK && buffer_empty_o && byte_seen)

  // A clear answers in the next cycle with an empty buffer and no data.
  `RXRB_ASSERT_NEXT(a_clear_result, clk_i, rst_ni,
                    in_fire && operation_i == OP_CLEAR,
                    out_valid_o && buffer_empty_o && !pop_was_empty_o && read_data_o == 8'd0)

  // A push answers in the next cycle with a non-empty buffer.
  `RXRB_ASSERT_NEXT(a_push_result, clk_i, rst_ni,
                    in_fire && operation_i == OP_PUSH,
                    out_valid_o && !buffer_empty_o && !pop_was_empty_o && read_data_o == 8'd0)

  // A stalled result holds.
  `RXRB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni,
                    out_valid_o && !out_ready_i,
                    out_valid_o && $stable(read_data_o) && $stable(pop_was_empty_o)
                    && $stable(buffer_empty_o))

endmodule

bind rx_byte_ring_buffer_drop_oldest rxrb_checker u_rxrb_checker (.*);
